// ===== hdl/drcsm_pkg.sv =====
// Shared constants and types for the dirty rectangle crop/scale mapper.
// No dependencies.
`default_nettype none
package drcsm_pkg;

    localparam int MAX_DIM   = 8192;
    localparam int POS_W     = 13;      // source corner width
    localparam int DIM_W     = 14;      // span and target width
    localparam int NUM_W     = 29;      // dividend width (span * target + divisor - 1)
    localparam int LANES     = 4;       // x, y, w, h
    localparam int DIV_STEPS = NUM_W;   // one quotient bit per stage
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_SPAN_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_SPAN_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd5;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_W = 2;
    localparam int LANE_H = 3;

    typedef struct packed {
        logic [DIM_W-1:0] span_y;
        logic [DIM_W-1:0] span_x;
        logic [POS_W-1:0] top;
        logic [POS_W-1:0] left;
    } rect_in_t;

endpackage
`default_nettype wire

// ===== hdl/dirty_rect_crop_scale_mapper.sv =====
// Dirty rectangle crop/scale mapper: clip, scale by pipelined restoring
// division, round to 2x2 blocks, grow and clamp. Depends on drcsm_pkg.
//
// Pipeline: input register, multiply, 29 one-bit divider stages,
//   round/grow stage, output register.
// Throughput: one request per cycle; the whole pipeline advances together and
//   holds only when the output register is full and not taken.
// Reset (rst_n low, async): pipeline valids cleared, crop offsets 0,
//   crop spans and target size 8192.
`default_nettype none
module dirty_rect_crop_scale_mapper (
    input  wire logic clk,
    input  wire logic rst_n,
    // input stream; tdata: rect_left[12:0], rect_top[25:13],
    // rect_span_x[39:26], rect_span_y[53:40], zero pad [55:54]
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [drcsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result stream; tdata: out_left[13:0], out_top[27:14],
    // out_span_x[41:28], out_span_y[55:42]
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [drcsm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [drcsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [drcsm_pkg::DIM_W-1:0]         cfg_data
);
    import drcsm_pkg::*;

    // ---------------- configuration registers ----------------
    logic [POS_W-1:0] crop_left_reg, crop_top_reg;
    logic [DIM_W-1:0] crop_span_x_reg, crop_span_y_reg;
    logic [DIM_W-1:0] target_width_reg, target_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crop_left_reg     <= '0;
            crop_top_reg      <= '0;
            crop_span_x_reg   <= DIM_RESET;
            crop_span_y_reg   <= DIM_RESET;
            target_width_reg  <= DIM_RESET;
            target_height_reg <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CROP_LEFT:     crop_left_reg     <= cfg_data[POS_W-1:0];
                REG_CROP_TOP:      crop_top_reg      <= cfg_data[POS_W-1:0];
                REG_CROP_SPAN_X:   crop_span_x_reg   <= cfg_data;
                REG_CROP_SPAN_Y:   crop_span_y_reg   <= cfg_data;
                REG_TARGET_WIDTH:  target_width_reg  <= cfg_data;
                REG_TARGET_HEIGHT: target_height_reg <= cfg_data;
                default: ; // indexes past the list are dropped
            endcase
        end
    end

    // Later stages read the live registers; the user must change config only while idle (not enforced here).
    logic scaled;
    assign scaled = (target_width_reg != crop_span_x_reg) ||
                    (target_height_reg != crop_span_y_reg);

    // Single pipeline enable: advance when the output slot is free or drained.
    logic out_valid_reg;
    logic adv;
    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- stage 0: input register ----------------
    rect_in_t in_reg;
    logic     in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (adv)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            in_reg <= rect_in_t'(s_axis_tdata[$bits(rect_in_t)-1:0]);
    end

    // ---------------- stage 1: reject, clip, multiply ----------------
    logic [POS_W+1:0] r_right, r_bottom, c_right, c_bottom;
    logic             outside;
    logic [POS_W-1:0] clip_x, clip_y;
    logic [DIM_W-1:0] clip_w, clip_h;

    always_comb
    begin
        r_right  = (POS_W+2)'(in_reg.left) + (POS_W+2)'(in_reg.span_x);
        r_bottom = (POS_W+2)'(in_reg.top)  + (POS_W+2)'(in_reg.span_y);
        c_right  = (POS_W+2)'(crop_left_reg) + (POS_W+2)'(crop_span_x_reg);
        c_bottom = (POS_W+2)'(crop_top_reg)  + (POS_W+2)'(crop_span_y_reg);
        outside  = (crop_span_x_reg == '0) || (crop_span_y_reg == '0) ||
                   (r_right < (POS_W+2)'(crop_left_reg)) ||
                   ((POS_W+2)'(in_reg.left) > c_right) ||
                   (r_bottom < (POS_W+2)'(crop_top_reg)) ||
                   ((POS_W+2)'(in_reg.top) > c_bottom);
        // left of crop: keep only the part inside, corner at 0
        if (in_reg.left < crop_left_reg)
        begin
            clip_x = '0;
            clip_w = DIM_W'(r_right - (POS_W+2)'(crop_left_reg));
        end
        else
        begin
            clip_x = in_reg.left - crop_left_reg;
            clip_w = in_reg.span_x;
        end
        if (in_reg.top < crop_top_reg)
        begin
            clip_y = '0;
            clip_h = DIM_W'(r_bottom - (POS_W+2)'(crop_top_reg));
        end
        else
        begin
            clip_y = in_reg.top - crop_top_reg;
            clip_h = in_reg.span_y;
        end
    end

    // divider pipeline: nq holds remaining dividend bits, quotient shifts in
    logic [NUM_W-1:0] nq_reg  [0:DIV_STEPS][0:LANES-1];
    logic [DIM_W-1:0] rem_reg [0:DIV_STEPS][0:LANES-1];
    logic [DIV_STEPS:0] dv_reg;
    logic [DIV_STEPS:0] dz_reg;

    logic [DIM_W-1:0] lane_div [0:LANES-1];
    assign lane_div[LANE_X] = crop_span_x_reg;
    assign lane_div[LANE_Y] = crop_span_y_reg;
    assign lane_div[LANE_W] = crop_span_x_reg;
    assign lane_div[LANE_H] = crop_span_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (adv)
            dv_reg[0] <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dz_reg[0] <= outside;
            nq_reg[0][LANE_X] <= NUM_W'(clip_x * target_width_reg);
            nq_reg[0][LANE_Y] <= NUM_W'(clip_y * target_height_reg);
            // ceiling: add divisor - 1 before the floor division
            nq_reg[0][LANE_W] <= NUM_W'(clip_w * target_width_reg)
                               + NUM_W'(crop_span_x_reg) - NUM_W'(1);
            nq_reg[0][LANE_H] <= NUM_W'(clip_h * target_height_reg)
                               + NUM_W'(crop_span_y_reg) - NUM_W'(1);
            for (int l = 0; l < LANES; l++)
                rem_reg[0][l] <= '0;
        end
    end

    // ---------------- stages 2..30: restoring divider, one bit each ----------------
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[g+1] <= 1'b0;
            else if (adv)
                dv_reg[g+1] <= dv_reg[g];
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [DIM_W:0] trial;
            logic           ge;
            always_comb
            begin
                trial = {rem_reg[g][l], nq_reg[g][l][NUM_W-1]};
                ge    = trial >= {1'b0, lane_div[l]};
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[g+1][l] <= ge ? DIM_W'(trial - {1'b0, lane_div[l]})
                                          : trial[DIM_W-1:0];
                    nq_reg[g+1][l]  <= {nq_reg[g][l][NUM_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dz_reg[g+1] <= dz_reg[g];
        end
    end

    // ---------------- stage 31: even 2x2 rounding and growth ----------------
    logic [NUM_W-1:0] qx, qy, qw, qh;
    assign qx = nq_reg[DIV_STEPS][LANE_X];
    assign qy = nq_reg[DIV_STEPS][LANE_Y];
    assign qw = nq_reg[DIV_STEPS][LANE_W];
    assign qh = nq_reg[DIV_STEPS][LANE_H];

    logic [NUM_W-1:0] x1, y1, x3, y3;
    logic [NUM_W+1:0] w1, h1, w2, h2, w3, h3;

    always_comb
    begin
        // odd corner moves down one, span grows one
        x1 = {qx[NUM_W-1:1], 1'b0};
        y1 = {qy[NUM_W-1:1], 1'b0};
        w1 = (NUM_W+2)'(qw) + (NUM_W+2)'(qx[0]);
        h1 = (NUM_W+2)'(qh) + (NUM_W+2)'(qy[0]);
        w2 = w1 + (NUM_W+2)'(w1[0]);
        h2 = h1 + (NUM_W+2)'(h1[0]);
        x3 = x1;
        y3 = y1;
        w3 = w2;
        h3 = h2;
        if (scaled)
        begin
            w3 = w2 + (NUM_W+2)'(2);
            h3 = h2 + (NUM_W+2)'(2);
            if (x1 != '0)
            begin
                x3 = x1 - NUM_W'(2);
                w3 = w2 + (NUM_W+2)'(4);
            end
            if (y1 != '0)
            begin
                y3 = y1 - NUM_W'(2);
                h3 = h2 + (NUM_W+2)'(4);
            end
        end
    end

    logic [NUM_W-1:0] gx_reg, gy_reg;
    logic [NUM_W+1:0] gw_reg, gh_reg;
    logic             gz_reg, gv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gv_reg <= 1'b0;
        else if (adv)
            gv_reg <= dv_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg <= x3;
            gy_reg <= y3;
            gw_reg <= w3;
            gh_reg <= h3;
            gz_reg <= dz_reg[DIV_STEPS];
        end
    end

    // ---------------- stage 32: clamp to scaled frame, output register ----------------
    logic             clamp_x, clamp_y, empty;
    logic [DIM_W-1:0] fw, fh;

    always_comb
    begin
        clamp_x = ((NUM_W+2)'(gx_reg) + gw_reg) > (NUM_W+2)'(target_width_reg);
        clamp_y = ((NUM_W+2)'(gy_reg) + gh_reg) > (NUM_W+2)'(target_height_reg);
        fw = clamp_x ? DIM_W'(target_width_reg - DIM_W'(gx_reg)) : gw_reg[DIM_W-1:0];
        fh = clamp_y ? DIM_W'(target_height_reg - DIM_W'(gy_reg)) : gh_reg[DIM_W-1:0];
        // clamped span is nonpositive exactly when the corner reaches the edge
        empty = gz_reg ||
                (clamp_x ? (gx_reg >= NUM_W'(target_width_reg)) : (gw_reg == '0)) ||
                (clamp_y ? (gy_reg >= NUM_W'(target_height_reg)) : (gh_reg == '0));
    end

    logic [OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= gv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= empty ? '0
                                  : {fh, fw, gy_reg[DIM_W-1:0], gx_reg[DIM_W-1:0]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    // an empty result is all zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[41:28] == '0 || m_axis_tdata[55:42] == '0)
        |-> m_axis_tdata == '0)
        else $error("empty result with nonzero fields");

    // input side stalls only while a result waits
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // a valid at the divider input that advances reaches the first divider stage unless the pipe holds
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[0] && adv) |=> (dv_reg[1] || !adv))
        else $error("valid lost in divider pipe");

endmodule
`default_nettype wire

// ===== dv/dirty_rect_crop_scale_mapper_tb.sv =====
// Self-checking testbench for dirty_rect_crop_scale_mapper: directed rectangles,
// then random ones over several crop/scale settings, with random stalls.
// Depends on drcsm_pkg and the mapper RTL.
`timescale 1ns / 100ps
`default_nettype none
module dirty_rect_crop_scale_mapper_tb;
    import drcsm_pkg::*;

    // indexes past the register file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int DRAIN_CYCLES  = 40;      // pipeline is 33 deep
    localparam int STALL_LIMIT   = 5000;    // cycles with no handshake on any channel
    localparam int IDLE_PCT      = 23;

    typedef struct packed {
        logic [DIM_W-1:0] span_y;
        logic [DIM_W-1:0] span_x;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] left;
    } mapped_t;

    typedef struct {
        logic [POS_W-1:0] left;
        logic [POS_W-1:0] top;
        logic [DIM_W-1:0] span_x;
        logic [DIM_W-1:0] span_y;
        bit               typed;    // expected value is given in the row
        mapped_t          res;
    } probe_t;

    logic clk;
    logic rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]       cfg_data;

    // shadow copy of the window registers
    longint win_left, win_top, win_span_x, win_span_y, tgt_w, tgt_h;

    mapped_t pending_rects[$];
    int      mismatches = 0;
    int      rects_sent = 0;
    int      rects_checked = 0;
    int      settings_used = 0;
    int      idle_cycles = 0;
    bit      quiet = 0;         // no stalls on either side while set

    dirty_rect_crop_scale_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Expected mapping of one rectangle under the current window.
    function automatic mapped_t map_rect(longint rl, longint rt, longint rw, longint rh);
        mapped_t r;
        longint x, y, w, h;
        r = '0;
        if (win_span_x == 0 || win_span_y == 0 ||
            rl + rw < win_left || rl > win_left + win_span_x ||
            rt + rh < win_top  || rt > win_top + win_span_y)
        begin
            return r;
        end
        // clip at the crop's left and top
        x = rl - win_left;
        w = rw;
        if (x < 0)
        begin
            w += x;
            x = 0;
        end
        y = rt - win_top;
        h = rh;
        if (y < 0)
        begin
            h += y;
            y = 0;
        end
        // corner floors, spans ceil
        x = (x * tgt_w) / win_span_x;
        y = (y * tgt_h) / win_span_y;
        w = (w * tgt_w + win_span_x - 1) / win_span_x;
        h = (h * tgt_h + win_span_y - 1) / win_span_y;
        // round out to 2x2 blocks
        if (x % 2 != 0)
        begin
            x--;
            w++;
        end
        if (y % 2 != 0)
        begin
            y--;
            h++;
        end
        if (w % 2 != 0) w++;
        if (h % 2 != 0) h++;
        // scaled: pad by 2 on the right and bottom, and on the left and top unless at 0
        if (tgt_w != win_span_x || tgt_h != win_span_y)
        begin
            if (x > 0)
            begin
                x -= 2;
                w += 2;
            end
            if (y > 0)
            begin
                y -= 2;
                h += 2;
            end
            w += 2;
            h += 2;
        end
        if (x + w > tgt_w) w = tgt_w - x;
        if (y + h > tgt_h) h = tgt_h - y;
        if (w <= 0 || h <= 0) return r;
        r.left   = x[DIM_W-1:0];
        r.top    = y[DIM_W-1:0];
        r.span_x = w[DIM_W-1:0];
        r.span_y = h[DIM_W-1:0];
        return r;
    endfunction

    // Wait for the pipeline to empty, then a little longer.
    task automatic wait_drained();
        while (pending_rects.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One burst of register writes; valid stays high across back-to-back requests.
    task automatic write_regs(input logic [CFG_IDX_W+DIM_W-1:0] reqs[$]);
        foreach (reqs[i])
        begin
            cfg_valid <= 1'b1;
            {cfg_index, cfg_data} <= reqs[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            case (reqs[i][DIM_W +: CFG_IDX_W])
                REG_CROP_LEFT:     win_left   = reqs[i][POS_W-1:0];
                REG_CROP_TOP:      win_top    = reqs[i][POS_W-1:0];
                REG_CROP_SPAN_X:   win_span_x = reqs[i][DIM_W-1:0];
                REG_CROP_SPAN_Y:   win_span_y = reqs[i][DIM_W-1:0];
                REG_TARGET_WIDTH:  tgt_w      = reqs[i][DIM_W-1:0];
                REG_TARGET_HEIGHT: tgt_h      = reqs[i][DIM_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(input logic [DIM_W-1:0] cl, ct, cw, ch, sw, sh,
                              input bit spare);
        logic [CFG_IDX_W+DIM_W-1:0] reqs[$];
        if (spare)
        begin
            reqs.push_back({REG_SPARE_6, DIM_W'($urandom)});
            reqs.push_back({REG_SPARE_7, DIM_W'($urandom)});
        end
        reqs.push_back({REG_CROP_LEFT, cl});
        reqs.push_back({REG_CROP_TOP, ct});
        reqs.push_back({REG_CROP_SPAN_X, cw});
        reqs.push_back({REG_CROP_SPAN_Y, ch});
        reqs.push_back({REG_TARGET_WIDTH, sw});
        reqs.push_back({REG_TARGET_HEIGHT, sh});
        wait_drained();
        write_regs(reqs);
        settings_used++;
    endtask

    // Send one rectangle and queue its expected mapping on acceptance.
    task automatic send_rect(input probe_t p);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, p.span_y, p.span_x, p.top, p.left};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_rects.push_back(p.typed ? p.res :
                                map_rect(p.left, p.top, p.span_x, p.span_y));
        rects_sent++;
    endtask

    // Random rectangle: mostly near the crop window, the rest anywhere.
    function automatic probe_t rand_rect();
        probe_t p;
        longint l, t;
        p = '{default: '0};
        if ($urandom_range(99) < 70)
        begin
            l = win_left + longint'($urandom_range(0, 2 * 64)) - 64;
            t = win_top + longint'($urandom_range(0, 2 * 64)) - 64;
            if ($urandom_range(1))
                l += longint'($urandom_range(0, 16383)) % (win_span_x + 1);
            if ($urandom_range(1))
                t += longint'($urandom_range(0, 16383)) % (win_span_y + 1);
            p.left   = l[POS_W-1:0];
            p.top    = t[POS_W-1:0];
            p.span_x = $urandom_range(3) == 0 ? DIM_W'($urandom) : DIM_W'($urandom_range(0, 300));
            p.span_y = $urandom_range(3) == 0 ? DIM_W'($urandom) : DIM_W'($urandom_range(0, 300));
        end
        else
        begin
            p.left   = POS_W'($urandom);
            p.top    = POS_W'($urandom);
            p.span_x = DIM_W'($urandom);
            p.span_y = DIM_W'($urandom);
        end
        return p;
    endfunction

    task automatic send_random(input int count, input bit hold_mid);
        for (int i = 0; i < count; i++)
        begin
            if (hold_mid && i == count / 2)
            begin
                // hold off until the pipeline has returned everything
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_rects.size() != 0) @(posedge clk);
            end
            send_rect(rand_rect());
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Directed rows under the reset window (1:1, 8192 square).
    probe_t probes[] = '{
        '{0,    0,    0,     0,     1, '{0, 0, 0, 0}},
        '{0,    0,    8192,  8192,  1, '{8192, 8192, 0, 0}},
        '{8191, 8191, 16383, 16383, 1, '{2, 2, 8190, 8190}},
        '{1,    1,    1,     1,     1, '{2, 2, 0, 0}},
        '{8191, 0,    1,     1,     1, '{2, 2, 0, 8190}},
        '{0,    8191, 16383, 0,     1, '{2, 8192, 8190, 0}},
        '{100,  200,  37,    55,    0, '{0, 0, 0, 0}},
        '{5461, 2730, 10922, 5461,  0, '{0, 0, 0, 0}},
        '{2730, 5461, 5461,  10922, 0, '{0, 0, 0, 0}},
        '{4095, 4096, 8191,  8190,  0, '{0, 0, 0, 0}}
    };

    // Result checker.
    function automatic void check_field(string name, logic [DIM_W-1:0] want,
                                        logic [DIM_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        mapped_t want, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_rects.size() == 0)
            begin
                $error("result with nothing outstanding: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_rects.pop_front();
                check_field("out_left",   want.left,   got.left);
                check_field("out_top",    want.top,    got.top);
                check_field("out_span_x", want.span_x, got.span_x);
                check_field("out_span_y", want.span_y, got.span_y);
                rects_checked++;
            end
        end
    end

    // Result-side backpressure.
    always @(posedge clk)
        m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog: too long without a handshake on any channel.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_CROP_LEFT;
        cfg_data      = '0;
        win_left = 0;
        win_top  = 0;
        win_span_x = MAX_DIM;
        win_span_y = MAX_DIM;
        tgt_w = MAX_DIM;
        tgt_h = MAX_DIM;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i]) send_rect(probes[i]);
        send_random(60, 0);

        // upscale, non-square; sender pauses to full drain midway
        set_window(100, 50, 640, 480, 1280, 720, 1);
        send_random(100, 1);
        // smallest crop, largest target
        set_window(0, 0, 1, 1, 8192, 8192, 0);
        send_random(70, 0);
        // far corner crop, smallest target; crop_left data beyond 13 bits
        set_window(14'h3FFF, 8191, 8192, 8192, 1, 1, 0);
        send_random(70, 0);
        // zero crop span in one axis, then the other
        set_window(10, 10, 0, 300, 500, 500, 0);
        send_random(40, 0);
        set_window(10, 10, 300, 0, 500, 500, 0);
        send_random(40, 0);
        // zero target size
        set_window(0, 0, 1000, 1000, 0, 0, 0);
        send_random(40, 0);
        // wide crop, tall crop: the vertical outside test must use the height
        set_window(200, 300, 4000, 100, 1920, 1080, 1);
        send_random(80, 0);
        set_window(300, 200, 100, 4000, 640, 2000, 0);
        send_random(80, 0);
        // long stretch with no stalls at all
        quiet = 1;
        send_random(150, 0);
        quiet = 0;
        for (int k = 0; k < 4; k++)
        begin
            set_window(DIM_W'($urandom), DIM_W'($urandom),
                       DIM_W'($urandom_range(1, 8192)), DIM_W'($urandom_range(1, 8192)),
                       DIM_W'($urandom_range(1, 8192)), DIM_W'($urandom_range(1, 8192)),
                       k[0]);
            send_random(60, 0);
        end

        wait_drained();
        $display("mapped %0d rectangles (%0d checked) over %0d window settings,",
                 rects_sent, rects_checked, settings_used + 1);
        $display("including empty, zero-span, zero-target and 1:1 cases");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
